// ----- hdl/dmsc_pkg.sv -----
package dmsc_pkg;

	// Request codes on the command field
	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_CHAN_EN = 2'd1;
	localparam logic [1:0] CMD_IRQ_EN  = 2'd2;

	// Configuration register port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ADDR = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LEN  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP        = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE        = 4'd3;

	localparam logic [15:0] ADDR_RESET = 16'hC000;
	localparam logic [15:0] ADDR_LAST  = 16'hFFFF;
	localparam logic [15:0] ADDR_WRAP  = 16'h8000;

	localparam logic [6:0] LEVEL_STEP     = 7'd2;
	localparam logic [6:0] LEVEL_RISE_MAX = 7'd125;
	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
	localparam logic [9:0] RATE_RESET     = 10'd428;

	typedef struct packed {
		logic [7:0] addr_code;
		logic [7:0] len_code;
		logic       loop_en;
		logic [9:0] rate_period;
	} dmsc_cfg_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [11:0] bytes_left;
		logic [7:0]  sample_byte;
		logic        buffer_full;
		logic [7:0]  shift_bits;
		logic [3:0]  bits_left;
		logic        silent;
		logic [6:0]  level;
		logic        irq_pending;
		logic        irq_allowed;
		logic [9:0]  rate_count;
	} dmsc_state_t;

	// start address = code*64 + 0xC000
	function automatic logic [15:0] start_addr(input logic [7:0] code);
		start_addr = {2'b11, code, 6'b000000};
	endfunction

	// byte count = code*16 + 1
	function automatic logic [11:0] start_len(input logic [7:0] code);
		start_len = {code, 4'b0001};
	endfunction

endpackage

// ----- hdl/dmsc_fetch.sv -----
module dmsc_fetch (
	input  dmsc_pkg::dmsc_cfg_t   cfg,
	input  dmsc_pkg::dmsc_state_t cur,
	input  logic [1:0]            cmd,
	input  logic                  en,
	input  logic [7:0]            data,
	output dmsc_pkg::dmsc_state_t mid
);

	// Sample fetch on a tick, plus the enable requests
	always_comb begin
		mid = cur;
		case (cmd)
			dmsc_pkg::CMD_TICK: begin
				if (!cur.buffer_full && cur.bytes_left != 12'd0) begin
					mid.sample_byte = data;
					mid.buffer_full = 1'b1;
					mid.addr        = (cur.addr == dmsc_pkg::ADDR_LAST) ?
					                  dmsc_pkg::ADDR_WRAP : cur.addr + 16'd1;
					mid.bytes_left  = cur.bytes_left - 12'd1;
					if (mid.bytes_left == 12'd0) begin
						if (cfg.loop_en) begin
							mid.addr       = dmsc_pkg::start_addr(cfg.addr_code);
							mid.bytes_left = dmsc_pkg::start_len(cfg.len_code);
						end else if (cur.irq_allowed) begin
							mid.irq_pending = 1'b1;
						end
					end
				end
			end
			dmsc_pkg::CMD_CHAN_EN: begin
				if (en && cur.bytes_left == 12'd0) begin
					mid.addr       = dmsc_pkg::start_addr(cfg.addr_code);
					mid.bytes_left = dmsc_pkg::start_len(cfg.len_code);
				end
				if (!en) begin
					mid.bytes_left = 12'd0;
				end
			end
			dmsc_pkg::CMD_IRQ_EN: begin
				mid.irq_allowed = en;
				if (!en) begin
					mid.irq_pending = 1'b0;
				end
			end
			default: begin
				mid = cur;
			end
		endcase
	end

endmodule

// ----- hdl/dmsc_output.sv -----
module dmsc_output (
	input  dmsc_pkg::dmsc_cfg_t   cfg,
	input  dmsc_pkg::dmsc_state_t mid,
	input  logic                  tick,
	output dmsc_pkg::dmsc_state_t nxt
);

	// Rate divider, shifter and level stepping
	always_comb begin
		nxt = mid;
		if (tick) begin
			if (mid.rate_count == 10'd0) begin
				nxt.rate_count = (cfg.rate_period == 10'd0) ? 10'd0 :
				                 cfg.rate_period - 10'd1;
				if (!mid.silent) begin
					if (!mid.shift_bits[0]) begin
						if (mid.level >= dmsc_pkg::LEVEL_STEP)
							nxt.level = mid.level - dmsc_pkg::LEVEL_STEP;
					end else begin
						if (mid.level <= dmsc_pkg::LEVEL_RISE_MAX)
							nxt.level = mid.level + dmsc_pkg::LEVEL_STEP;
					end
				end
				nxt.shift_bits = mid.shift_bits >> 1;
				if (mid.bits_left != 4'd0)
					nxt.bits_left = mid.bits_left - 4'd1;
				// start a new output cycle from the buffer, silent if empty
				if (nxt.bits_left == 4'd0) begin
					nxt.bits_left = dmsc_pkg::BITS_PER_BYTE;
					if (!mid.buffer_full) begin
						nxt.silent = 1'b1;
					end else begin
						nxt.silent      = 1'b0;
						nxt.shift_bits  = mid.sample_byte;
						nxt.buffer_full = 1'b0;
					end
				end
			end else begin
				nxt.rate_count = mid.rate_count - 10'd1;
			end
		end
	end

endmodule

// ----- hdl/delta_modulation_sample_channel_core.sv -----
// A request is captured in the request register on acceptance; its result is captured in
// the result register when the request issues, which waits while the result slot is held.
// One request per clock while the result slot is free or being taken; the fetch and divider
// logic between the request register and the result register updates the channel state.
// Reset (arst_n low, asynchronous): channel state, configuration registers and valid flags cleared;
// rate period returns to 428, address counter to 0xC000, output silent at level 0.
module delta_modulation_sample_channel_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dmsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        command,
	input  logic                              enable_bit,
	input  logic [7:0]                        fetch_data,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [6:0]                        dac_level,
	output logic                              irq,
	output logic [15:0]                       fetch_address,
	output logic                              active
);

	dmsc_pkg::dmsc_cfg_t   cfg_q;
	dmsc_pkg::dmsc_state_t st_q;
	dmsc_pkg::dmsc_state_t mid;
	dmsc_pkg::dmsc_state_t nxt;

	logic       vld_s1;
	logic [1:0] cmd_s1;
	logic       en_s1;
	logic [7:0] data_s1;

	logic       vld_s2;
	logic [6:0] level_s2;
	logic       irq_s2;
	logic [15:0] addr_s2;
	logic       active_s2;

	logic advance;
	logic issue;

	// The user must write registers only while the channel is idle; the block does not enforce it, so always accept.
	assign cfg_ready = 1'b1;

	// The result slot frees when it is empty or being taken; the request register
	// advances into it at that point and can take a fresh request in the same cycle.
	assign advance  = !vld_s2 || out_ready;
	assign issue    = vld_s1 && advance;
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_code   <= 8'd0;
			cfg_q.len_code    <= 8'd0;
			cfg_q.loop_en     <= 1'b0;
			cfg_q.rate_period <= dmsc_pkg::RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dmsc_pkg::REG_SAMPLE_ADDR: cfg_q.addr_code   <= cfg_data[7:0];
				dmsc_pkg::REG_SAMPLE_LEN:  cfg_q.len_code    <= cfg_data[7:0];
				dmsc_pkg::REG_LOOP:        cfg_q.loop_en     <= cfg_data[0];
				dmsc_pkg::REG_RATE:        cfg_q.rate_period <= cfg_data;
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	// Request register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			en_s1   <= enable_bit;
			data_s1 <= fetch_data;
		end
	end

	// Byte fetch and enable requests first, then the divider and level logic
	// see the buffer as the fetch left it.
	dmsc_fetch u_fetch (
		.cfg  (cfg_q),
		.cur  (st_q),
		.cmd  (cmd_s1),
		.en   (en_s1),
		.data (data_s1),
		.mid  (mid)
	);

	dmsc_output u_output (
		.cfg  (cfg_q),
		.mid  (mid),
		.tick (cmd_s1 == dmsc_pkg::CMD_TICK),
		.nxt  (nxt)
	);

	// Channel state: advance only as a request issues.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.addr        <= dmsc_pkg::ADDR_RESET;
			st_q.bytes_left  <= 12'd0;
			st_q.sample_byte <= 8'd0;
			st_q.buffer_full <= 1'b0;
			st_q.shift_bits  <= 8'd0;
			st_q.bits_left   <= 4'd0;
			st_q.silent      <= 1'b1;
			st_q.level       <= 7'd0;
			st_q.irq_pending <= 1'b0;
			st_q.irq_allowed <= 1'b0;
			st_q.rate_count  <= 10'd0;
		end else if (issue) begin
			st_q <= nxt;
		end
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			level_s2  <= nxt.level;
			irq_s2    <= nxt.irq_pending;
			addr_s2   <= nxt.addr;
			active_s2 <= (nxt.bytes_left != 12'd0);
		end
	end

	assign out_valid     = vld_s2;
	assign dac_level     = level_s2;
	assign irq           = irq_s2;
	assign fetch_address = addr_s2;
	assign active        = active_s2;

	// The bit counter never runs past one byte.
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bits_left <= dmsc_pkg::BITS_PER_BYTE)
		else $error("bit counter beyond one byte");

	// An empty bit counter only exists before the first output cycle, which is silent.
	a_bits_silent: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bits_left == 4'd0 |-> st_q.silent)
		else $error("non-silent channel with empty bit counter");

	// State moves only when a request issues.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!issue |=> $stable(st_q))
		else $error("channel state changed without a request");

	// The level steps by two at most per request.
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (st_q.level == $past(st_q.level)) ||
		          (st_q.level == $past(st_q.level) + 7'd2) ||
		          (st_q.level == $past(st_q.level) - 7'd2))
		else $error("level moved by more than one step");

	// A request held in the stage while the result slot is blocked stays there.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(cmd_s1) && $stable(data_s1))
		else $error("stalled request lost");

endmodule

// ----- bench/tb_delta_modulation_sample_channel_core.sv -----
`timescale 1ns / 100ps

module tb_delta_modulation_sample_channel_core;

	// Allow for the slowest legal run several times over
	localparam int CYCLE_LIMIT = 1000000;

	// Command code with no meaning, and the highest register index
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [dmsc_pkg::CFG_IDX_W-1:0] REG_IDX_TOP = 4'd15;

	// One result as the channel reports it
	typedef struct packed {
		logic [6:0]  level;
		logic        irq;
		logic [15:0] addr;
		logic        active;
	} dac_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dmsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dmsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [1:0]                      command = dmsc_pkg::CMD_TICK;
	logic                            enable_bit = 1'b0;
	logic [7:0]                      fetch_data = 8'd0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [6:0]                      dac_level;
	logic                            irq;
	logic [15:0]                     fetch_address;
	logic                            active;

	// Shadow copy of the channel: registers and internal state
	dmsc_pkg::dmsc_cfg_t   shadow_cfg;
	dmsc_pkg::dmsc_state_t shadow_chan;

	// Results still owed by the channel, oldest first
	dac_result_t awaited_outputs[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	// Random idling on both sides is switched per test
	bit idle_on = 1'b1;
	// Long receiver hold-off, picked up by the receiver process
	int hold_req = 0;

	delta_modulation_sample_channel_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.enable_bit    (enable_bit),
		.fetch_data    (fetch_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.dac_level     (dac_level),
		.irq           (irq),
		.fetch_address (fetch_address),
		.active        (active)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow model of the channel
	// ------------------------------------------------------------------

	function automatic void reset_shadow();
		shadow_cfg.addr_code   = 8'd0;
		shadow_cfg.len_code    = 8'd0;
		shadow_cfg.loop_en     = 1'b0;
		shadow_cfg.rate_period = dmsc_pkg::RATE_RESET;
		shadow_chan             = '0;
		shadow_chan.addr        = dmsc_pkg::ADDR_RESET;
		shadow_chan.silent      = 1'b1;
	endfunction

	// Reload address and byte count from the start registers
	function automatic void restart_sample();
		shadow_chan.addr       = dmsc_pkg::ADDR_RESET + {8'd0, shadow_cfg.addr_code} * 16'd64;
		shadow_chan.bytes_left = {4'd0, shadow_cfg.len_code} * 12'd16 + 12'd1;
	endfunction

	// Shift one bit into the level, then open a new output cycle after eight
	function automatic void shift_out_bit();
		if (!shadow_chan.silent) begin
			if (!shadow_chan.shift_bits[0]) begin
				if (shadow_chan.level >= dmsc_pkg::LEVEL_STEP)
					shadow_chan.level = shadow_chan.level - dmsc_pkg::LEVEL_STEP;
			end else if (shadow_chan.level <= dmsc_pkg::LEVEL_RISE_MAX) begin
				shadow_chan.level = shadow_chan.level + dmsc_pkg::LEVEL_STEP;
			end
		end
		shadow_chan.shift_bits = shadow_chan.shift_bits >> 1;
		if (shadow_chan.bits_left != 4'd0)
			shadow_chan.bits_left = shadow_chan.bits_left - 4'd1;
		if (shadow_chan.bits_left == 4'd0) begin
			shadow_chan.bits_left = dmsc_pkg::BITS_PER_BYTE;
			// An empty buffer at the start of a cycle gives silence
			if (!shadow_chan.buffer_full) begin
				shadow_chan.silent = 1'b1;
			end else begin
				shadow_chan.silent      = 1'b0;
				shadow_chan.shift_bits  = shadow_chan.sample_byte;
				shadow_chan.buffer_full = 1'b0;
			end
		end
	endfunction

	// Predict the result of one request and advance the shadow state
	function automatic dac_result_t advance_channel(input logic [1:0] cmd, input logic en,
			input logic [7:0] data);
		dac_result_t res;
		case (cmd)
			dmsc_pkg::CMD_TICK: begin
				if (!shadow_chan.buffer_full && shadow_chan.bytes_left != 12'd0) begin
					shadow_chan.sample_byte = data;
					shadow_chan.buffer_full = 1'b1;
					shadow_chan.addr = (shadow_chan.addr == dmsc_pkg::ADDR_LAST) ?
						dmsc_pkg::ADDR_WRAP : shadow_chan.addr + 16'd1;
					shadow_chan.bytes_left = shadow_chan.bytes_left - 12'd1;
					// Out of bytes: loop round, or raise the interrupt if allowed
					if (shadow_chan.bytes_left == 12'd0) begin
						if (shadow_cfg.loop_en)
							restart_sample();
						else if (shadow_chan.irq_allowed)
							shadow_chan.irq_pending = 1'b1;
					end
				end
				// Reloading divider; a zero period behaves as a period of one
				if (shadow_chan.rate_count == 10'd0) begin
					shadow_chan.rate_count = (shadow_cfg.rate_period == 10'd0) ? 10'd0
						: shadow_cfg.rate_period - 10'd1;
					shift_out_bit();
				end else begin
					shadow_chan.rate_count = shadow_chan.rate_count - 10'd1;
				end
			end
			dmsc_pkg::CMD_CHAN_EN: begin
				// Enabling restarts only an exhausted sample; disabling leaves the irq alone
				if (en && shadow_chan.bytes_left == 12'd0)
					restart_sample();
				if (!en)
					shadow_chan.bytes_left = 12'd0;
			end
			dmsc_pkg::CMD_IRQ_EN: begin
				shadow_chan.irq_allowed = en;
				if (!en)
					shadow_chan.irq_pending = 1'b0;
			end
			default: begin
				// Unused code: state held, result still given
			end
		endcase
		res.level  = shadow_chan.level;
		res.irq    = shadow_chan.irq_pending;
		res.addr   = shadow_chan.addr;
		res.active = (shadow_chan.bytes_left != 12'd0);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 85)
			return int'($urandom_range(1, 3));
		else if (r < 97)
			return int'($urandom_range(4, 9));
		return int'($urandom_range(10, 40));
	endfunction

	// Offer one request, hold it until taken, then record what it must produce
	task automatic send_request(input logic [1:0] cmd, input logic en, input logic [7:0] data);
		int gap;
		gap = (idle_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		command    = cmd;
		enable_bit = en;
		fetch_data = data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		awaited_outputs.push_back(advance_channel(cmd, en, data));
	endtask

	task automatic send_tick(input logic [7:0] data);
		send_request(dmsc_pkg::CMD_TICK, 1'b0, data);
	endtask

	// Drop the request line and wait until every owed result has arrived
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write, only ever issued with the channel idle
	task automatic write_register(input logic [dmsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [dmsc_pkg::CFG_DATA_W-1:0] value);
		wait_for_drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dmsc_pkg::REG_SAMPLE_ADDR: shadow_cfg.addr_code   = value[7:0];
			dmsc_pkg::REG_SAMPLE_LEN:  shadow_cfg.len_code    = value[7:0];
			dmsc_pkg::REG_LOOP:        shadow_cfg.loop_en     = value[0];
			dmsc_pkg::REG_RATE:        shadow_cfg.rate_period = value;
			default: begin
				// Unmapped index: ignored
			end
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_channel(input logic [7:0] addr_code, input logic [7:0] len_code,
			input logic loop_en, input logic [9:0] rate);
		write_register(dmsc_pkg::REG_SAMPLE_ADDR, {2'b00, addr_code});
		write_register(dmsc_pkg::REG_SAMPLE_LEN, {2'b00, len_code});
		write_register(dmsc_pkg::REG_LOOP, {9'd0, loop_en});
		write_register(dmsc_pkg::REG_RATE, rate);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
			want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every request code at the reset settings, data at its extremes and in alternating patterns
	task automatic test_directed();
		send_tick(8'h00);
		send_tick(8'hFF);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		send_tick(8'hFF);
		send_tick(8'h00);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'hFF);
		send_request(dmsc_pkg::CMD_IRQ_EN, 1'b1, 8'h00);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h55);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b0, 8'hAA);
		send_request(dmsc_pkg::CMD_IRQ_EN, 1'b0, 8'hFF);
		send_request(CMD_UNUSED, 1'b1, 8'hFF);
		send_request(CMD_UNUSED, 1'b0, 8'h00);
		send_tick(8'hA5);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		send_tick(8'h5A);
		send_tick(8'hFF);
	endtask

	// Interrupt raised at the end of a one-byte sample, kept by a disable, cleared by irq off
	task automatic test_irq_and_stop();
		set_channel(8'd0, 8'd0, 1'b0, 10'd1);
		send_request(dmsc_pkg::CMD_IRQ_EN, 1'b1, 8'h00);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		repeat (20) send_tick(8'($urandom_range(0, 255)));
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b0, 8'h00);
		repeat (10) send_tick(8'($urandom_range(0, 255)));
		send_request(dmsc_pkg::CMD_IRQ_EN, 1'b0, 8'h00);
		send_request(CMD_UNUSED, 1'b1, 8'h3C);
		// Looping with the interrupt allowed must never raise it
		write_register(dmsc_pkg::REG_LOOP, 10'd1);
		send_request(dmsc_pkg::CMD_IRQ_EN, 1'b1, 8'h00);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		repeat (40) send_tick(8'($urandom_range(0, 255)));
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b0, 8'h00);
	endtask

	// Drive the level into both limits; the falling half runs at a zero rate period
	task automatic test_level_limits();
		set_channel(8'($urandom_range(0, 255)), 8'd255, 1'b1, 10'd1);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		repeat (100) send_tick(8'hFF);
		write_register(dmsc_pkg::REG_RATE, 10'd0);
		repeat (100) send_tick(8'h00);
		repeat (40) send_tick(8'hAA);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b0, 8'h00);
	endtask

	// Start at the top code so the fetch address crosses 0xFFFF, then loops back
	task automatic test_address_wrap();
		set_channel(8'd255, 8'd4, 1'b1, 10'd1);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		repeat (560) send_tick(8'($urandom_range(0, 255)));
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b0, 8'h00);
	endtask

	// Writes to unmapped indexes must leave every register as it was
	task automatic test_unmapped_registers();
		for (int i = 4; i < 16; i++)
			write_register(i[dmsc_pkg::CFG_IDX_W-1:0], 10'($urandom_range(0, 1023)));
		write_register(REG_IDX_TOP, 10'h3FF);
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		repeat (20) send_tick(8'($urandom_range(0, 255)));
	endtask

	// Hold the receiver off while requests keep coming so the input stalls
	task automatic test_backpressure();
		set_channel(8'($urandom_range(0, 255)), 8'd1, 1'b1, 10'd2);
		idle_on  = 1'b0;
		hold_req = 300;
		send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'h00);
		repeat (80) send_tick(8'($urandom_range(0, 255)));
		// Pause the sender until everything owed has come back
		wait_for_drain();
		repeat (40) send_tick(8'($urandom_range(0, 255)));
		idle_on = 1'b1;
	endtask

	// Random requests across several settings, extremes first
	task automatic test_random();
		int r;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0)
				set_channel(8'd0, 8'd0, 1'b0, 10'd1023);
			else if (phase == 1)
				set_channel(8'd255, 8'd255, 1'b1, 10'd1);
			else if (phase == 2)
				set_channel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)), 1'b0,
					10'd0);
			else
				set_channel(8'($urandom_range(0, 255)),
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)),
					($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
						: 10'($urandom_range(1, 8)));
			send_request(dmsc_pkg::CMD_IRQ_EN, 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)));
			send_request(dmsc_pkg::CMD_CHAN_EN, 1'b1, 8'($urandom_range(0, 255)));
			repeat (25) begin
				r = int'($urandom_range(0, 99));
				if (r < 82)
					send_tick(8'($urandom_range(0, 255)));
				else if (r < 92)
					send_request(dmsc_pkg::CMD_CHAN_EN, $urandom_range(0, 9) < 7,
						8'($urandom_range(0, 255)));
				else if (r < 97)
					send_request(dmsc_pkg::CMD_IRQ_EN, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
				else
					send_request(CMD_UNUSED, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
				if ($urandom_range(0, 199) == 0)
					wait_for_drain();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (idle_on && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// Compare every accepted result with the oldest one owed
	always @(posedge clk) begin
		dac_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outputs.size() == 0) begin
				flag_mismatch("unrequested result, level", int'(dac_level), 0);
			end else begin
				want = awaited_outputs.pop_front();
				if (dac_level !== want.level)
					flag_mismatch("dac_level", int'(dac_level), int'(want.level));
				if (irq !== want.irq)
					flag_mismatch("irq", int'(irq), int'(want.irq));
				if (fetch_address !== want.addr)
					flag_mismatch("fetch_address", int'(fetch_address), int'(want.addr));
				if (active !== want.active)
					flag_mismatch("active", int'(active), int'(want.active));
			end
		end
	end

	// Watchdog: end a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("delta_modulation_sample_channel_core test failed");
		$finish;
	end

	initial begin
		reset_shadow();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_irq_and_stop();
		test_level_limits();
		test_address_wrap();
		test_unmapped_registers();
		test_backpressure();
		test_random();

		wait_for_drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && awaited_outputs.size() == 0)
			$display("delta_modulation_sample_channel_core test passed");
		else
			$display("delta_modulation_sample_channel_core test failed");
		$finish;
	end

endmodule
